[src/lrat_pkg.sv]
package lrat_pkg;

  localparam int unsigned POS_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned OP_W = 2;
  localparam int unsigned MARK_W = 2;
  localparam int unsigned DEF_LEAVES = 1024;

  localparam logic [OP_W-1:0] OP_FILL = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef enum logic [MARK_W-1:0] {
    MARK_NONE  = 2'd0,
    MARK_FILL  = 2'd1,
    MARK_CLEAR = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREAD,
    S_PCHK,
    S_PW1,
    S_PW2,
    S_PW3,
    S_ASPLIT,
    S_ALEFT,
    S_ARIGHT,
    S_RES
  } state_e;

endpackage

[src/lrat_req_if.sv]
interface lrat_req_if;
  logic                        valid;
  logic                        ready;
  logic [lrat_pkg::OP_W-1:0]  operation;
  logic [lrat_pkg::POS_W-1:0] range_low;
  logic [lrat_pkg::POS_W-1:0] range_high;
  logic [lrat_pkg::POS_W-1:0] query_index;

  modport source (output valid, operation, range_low, range_high, query_index, input ready);
  modport sink (input valid, operation, range_low, range_high, query_index, output ready);
endinterface

[src/lrat_rsp_if.sv]
interface lrat_rsp_if;
  logic valid;
  logic ready;
  logic leaf_value;
  logic index_error;

  modport source (output valid, leaf_value, index_error, input ready);
  modport sink (input valid, leaf_value, index_error, output ready);
endinterface

[src/lrat_ram.sv]
module lrat_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lazy_range_assign_tree.sv]
// Lazy range-assign tree over one-bit leaves. Each node of the tree keeps a pending
// assignment mark in one single-port-write RAM of 4*LEAVES two-bit entries; a leaf's
// value is the topmost mark on its root path. A read walks root to leaf and returns
// at the first marked node. A fill or clear first pushes marks down along the paths
// to both range ends, moving a marked node's mark onto both children, then writes
// the covering nodes. One item is in work at a time; a finished read waits in the
// output register while the next item is taken. After reset and after every
// leaf_count write the RAM is swept clear, all 4*LEAVES entries, with no item taken.
module lazy_range_assign_tree #(
  parameter int unsigned LEAVES = lrat_pkg::DEF_LEAVES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrat_pkg::CNT_W-1:0]  cfg_data_i,
  lrat_req_if.sink                    req_i,
  lrat_rsp_if.source                  rsp_o
);

  localparam int unsigned DEPTH = 4 * LEAVES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = lrat_pkg::POS_W;

  lrat_pkg::state_e state_q, state_d;
  logic [lrat_pkg::CNT_W-1:0] leaf_count_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] k_q, k_d, k2_q, k2_d;
  logic [PW-1:0] l_q, l_d, r_q, r_d, l2_q, l2_d, r2_q, r2_d;
  logic [PW-1:0] a_q, a_d, b_q, b_d;
  logic [lrat_pkg::OP_W-1:0] op_q, op_d;
  logic pass_q, pass_d;
  lrat_pkg::mark_e mark_q, mark_d, pm_q, pm_d, rmark;
  logic res_val_q, res_val_d, res_err_q, res_err_d;
  logic rsp_valid_q, rsp_valid_d, leaf_q, leaf_d, err_q, err_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [lrat_pkg::MARK_W-1:0] ram_wdata, ram_rdata;

  logic [lrat_pkg::CNT_W-1:0] n_use;
  logic [PW-1:0] nm1, mid, tgt;
  logic [PW:0] lr_sum;
  logic [AW-1:0] kl, kr;
  logic req_fire, rsp_free, at_leaf, go_left, upd_ok, qry_bad, is_upd;

  lrat_ram #(
    .WIDTH(lrat_pkg::MARK_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (leaf_count_q == '0) begin
      n_use = lrat_pkg::CNT_W'(1);
    end else if (32'(leaf_count_q) > LEAVES) begin
      n_use = lrat_pkg::CNT_W'(LEAVES);
    end else begin
      n_use = leaf_count_q;
    end
  end

  assign nm1 = PW'(n_use - lrat_pkg::CNT_W'(1));
  assign lr_sum = {1'b0, l_q} + {1'b0, r_q};
  assign mid = lr_sum[PW:1];
  assign kl = {k_q[AW-2:0], 1'b0};
  assign kr = {k_q[AW-2:0], 1'b1};
  assign tgt = pass_q ? b_q : a_q;
  assign go_left = (tgt <= mid);
  assign at_leaf = (l_q == r_q);
  assign rmark = lrat_pkg::mark_e'(ram_rdata);
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign is_upd = (req_i.operation == lrat_pkg::OP_FILL) ||
                  (req_i.operation == lrat_pkg::OP_CLEAR);
  assign upd_ok = (req_i.range_low <= req_i.range_high) &&
                  ({1'b0, req_i.range_high} < n_use);
  assign qry_bad = ({1'b0, req_i.query_index} >= n_use);

  assign req_i.ready = (state_q == lrat_pkg::S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.leaf_value = leaf_q;
  assign rsp_o.index_error = err_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrat_pkg::S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = lrat_pkg::S_IDLE;
      end
      lrat_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req_i.operation == lrat_pkg::OP_READ) begin
            state_d = qry_bad ? lrat_pkg::S_RES : lrat_pkg::S_PREAD;
          end else if (is_upd && upd_ok) begin
            state_d = lrat_pkg::S_PREAD;
          end
        end
      end
      lrat_pkg::S_PREAD: state_d = lrat_pkg::S_PCHK;
      lrat_pkg::S_PCHK: begin
        if (op_q == lrat_pkg::OP_READ) begin
          if (rmark != lrat_pkg::MARK_NONE || at_leaf) state_d = lrat_pkg::S_RES;
          else state_d = lrat_pkg::S_PREAD;
        end else if (at_leaf) begin
          state_d = pass_q ? lrat_pkg::S_ASPLIT : lrat_pkg::S_PREAD;
        end else if (rmark != lrat_pkg::MARK_NONE) begin
          state_d = lrat_pkg::S_PW1;
        end else begin
          state_d = lrat_pkg::S_PREAD;
        end
      end
      lrat_pkg::S_PW1: state_d = lrat_pkg::S_PW2;
      lrat_pkg::S_PW2: state_d = lrat_pkg::S_PW3;
      lrat_pkg::S_PW3: state_d = lrat_pkg::S_PREAD;
      lrat_pkg::S_ASPLIT: begin
        if (l_q == a_q && r_q == b_q) state_d = lrat_pkg::S_IDLE;
        else if (b_q > mid && a_q <= mid) state_d = lrat_pkg::S_ALEFT;
      end
      lrat_pkg::S_ALEFT: begin
        if (l_q == a_q) state_d = lrat_pkg::S_ARIGHT;
      end
      lrat_pkg::S_ARIGHT: begin
        if (r_q == b_q) state_d = lrat_pkg::S_IDLE;
      end
      lrat_pkg::S_RES: begin
        if (rsp_free) state_d = lrat_pkg::S_IDLE;
      end
      default: state_d = lrat_pkg::S_IDLE;
    endcase
    if (cfg_we_i) state_d = lrat_pkg::S_CLEAR;
  end

  always_comb begin
    clr_d = clr_q;
    k_d = k_q;
    l_d = l_q;
    r_d = r_q;
    k2_d = k2_q;
    l2_d = l2_q;
    r2_d = r2_q;
    a_d = a_q;
    b_d = b_q;
    op_d = op_q;
    pass_d = pass_q;
    mark_d = mark_q;
    pm_d = pm_q;
    res_val_d = res_val_q;
    res_err_d = res_err_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    leaf_d = leaf_q;
    err_d = err_q;
    ram_we = 1'b0;
    ram_waddr = k_q;
    ram_wdata = lrat_pkg::MARK_NONE;
    ram_raddr = k_q;
    case (state_q)
      lrat_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      lrat_pkg::S_IDLE: begin
        if (req_fire) begin
          op_d = req_i.operation;
          a_d = (req_i.operation == lrat_pkg::OP_READ) ? req_i.query_index
                                                        : req_i.range_low;
          b_d = req_i.range_high;
          k_d = AW'(1);
          l_d = '0;
          r_d = nm1;
          pass_d = 1'b0;
          mark_d = (req_i.operation == lrat_pkg::OP_FILL) ? lrat_pkg::MARK_FILL
                                                          : lrat_pkg::MARK_CLEAR;
          res_val_d = 1'b0;
          res_err_d = qry_bad;
        end
      end
      lrat_pkg::S_PCHK: begin
        pm_d = rmark;
        if (op_q == lrat_pkg::OP_READ) begin
          res_val_d = (rmark == lrat_pkg::MARK_FILL);
          res_err_d = 1'b0;
          if (rmark == lrat_pkg::MARK_NONE && !at_leaf) begin
            if (go_left) begin
              k_d = kl;
              r_d = mid;
            end else begin
              k_d = kr;
              l_d = mid + PW'(1);
            end
          end
        end else if (at_leaf) begin
          pass_d = 1'b1;
          k_d = AW'(1);
          l_d = '0;
          r_d = nm1;
        end else if (rmark == lrat_pkg::MARK_NONE) begin
          if (go_left) begin
            k_d = kl;
            r_d = mid;
          end else begin
            k_d = kr;
            l_d = mid + PW'(1);
          end
        end
      end
      lrat_pkg::S_PW1: begin
        ram_we = 1'b1;
        ram_waddr = kl;
        ram_wdata = pm_q;
      end
      lrat_pkg::S_PW2: begin
        ram_we = 1'b1;
        ram_waddr = kr;
        ram_wdata = pm_q;
      end
      lrat_pkg::S_PW3: begin
        ram_we = 1'b1;
        if (go_left) begin
          k_d = kl;
          r_d = mid;
        end else begin
          k_d = kr;
          l_d = mid + PW'(1);
        end
      end
      lrat_pkg::S_ASPLIT: begin
        if (l_q == a_q && r_q == b_q) begin
          ram_we = 1'b1;
          ram_wdata = mark_q;
        end else if (b_q <= mid) begin
          k_d = kl;
          r_d = mid;
        end else if (a_q > mid) begin
          k_d = kr;
          l_d = mid + PW'(1);
        end else begin
          k2_d = kr;
          l2_d = mid + PW'(1);
          r2_d = r_q;
          k_d = kl;
          r_d = mid;
        end
      end
      lrat_pkg::S_ALEFT: begin
        if (l_q == a_q) begin
          ram_we = 1'b1;
          ram_wdata = mark_q;
          k_d = k2_q;
          l_d = l2_q;
          r_d = r2_q;
        end else if (a_q > mid) begin
          k_d = kr;
          l_d = mid + PW'(1);
        end else begin
          ram_we = 1'b1;
          ram_waddr = kr;
          ram_wdata = mark_q;
          k_d = kl;
          r_d = mid;
        end
      end
      lrat_pkg::S_ARIGHT: begin
        if (r_q == b_q) begin
          ram_we = 1'b1;
          ram_wdata = mark_q;
        end else if (b_q <= mid) begin
          k_d = kl;
          r_d = mid;
        end else begin
          ram_we = 1'b1;
          ram_waddr = kl;
          ram_wdata = mark_q;
          k_d = kr;
          l_d = mid + PW'(1);
        end
      end
      lrat_pkg::S_RES: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          leaf_d = res_val_q;
          err_d = res_err_q;
        end
      end
      default: ;
    endcase
    if (cfg_we_i) clr_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrat_pkg::S_CLEAR;
      clr_q <= '0;
      leaf_count_q <= lrat_pkg::CNT_W'(LEAVES);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) leaf_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    l_q <= l_d;
    r_q <= r_d;
    k2_q <= k2_d;
    l2_q <= l2_d;
    r2_q <= r2_d;
    a_q <= a_d;
    b_q <= b_d;
    op_q <= op_d;
    pass_q <= pass_d;
    mark_q <= mark_d;
    pm_q <= pm_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    leaf_q <= leaf_d;
    err_q <= err_d;
  end

`ifndef SYNTHESIS
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("item taken during clear sweep");
  a_rsp_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> op_q == lrat_pkg::OP_READ)
    else $error("beat without read");
  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrat_pkg::S_PCHK || state_q == lrat_pkg::S_ASPLIT) |-> l_q <= r_q)
    else $error("node bounds crossed");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lrat_pkg::S_IDLE |-> !ram_we)
    else $error("store written while idle");
`endif

endmodule
